// ===== rtl/egaq_pkg.sv =====
// ----------------------------------------------------------------------------
// egaq_pkg - shared types and palette for the EGA color quantizer
// Holds the pixel and distance types and the fixed 16-entry EGA palette.
// ----------------------------------------------------------------------------
`default_nettype none

package egaq_pkg;

  // Number of palette entries and widths that follow from the fixed fields
  localparam int PAL_SIZE   = 16;
  localparam int CHAN_W     = 8;
  localparam int IDX_W      = 4;
  localparam int DIST_W     = 10;   // 3 * 255 = 765 fits in 10 bits

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DIST_W-1:0] dist_t;

  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  // One distance per palette entry, entry 0 in the lowest slot
  typedef dist_t [PAL_SIZE-1:0] dist_vec_t;

  // Palette channel levels
  localparam chan_t LVL_0 = 8'h00;
  localparam chan_t LVL_1 = 8'h55;
  localparam chan_t LVL_2 = 8'haa;
  localparam chan_t LVL_3 = 8'hff;

  // Fixed EGA palette, looked up by index
  function automatic pixel_t pal_rgb(idx_t idx);
    pixel_t p;
    case (idx)
      4'd0:    p = '{red: LVL_0, green: LVL_0, blue: LVL_0};
      4'd1:    p = '{red: LVL_0, green: LVL_0, blue: LVL_2};
      4'd2:    p = '{red: LVL_0, green: LVL_2, blue: LVL_0};
      4'd3:    p = '{red: LVL_0, green: LVL_2, blue: LVL_2};
      4'd4:    p = '{red: LVL_2, green: LVL_0, blue: LVL_0};
      4'd5:    p = '{red: LVL_2, green: LVL_0, blue: LVL_2};
      4'd6:    p = '{red: LVL_2, green: LVL_1, blue: LVL_0};
      4'd7:    p = '{red: LVL_2, green: LVL_2, blue: LVL_2};
      4'd8:    p = '{red: LVL_1, green: LVL_1, blue: LVL_1};
      4'd9:    p = '{red: LVL_1, green: LVL_1, blue: LVL_3};
      4'd10:   p = '{red: LVL_1, green: LVL_3, blue: LVL_1};
      4'd11:   p = '{red: LVL_1, green: LVL_3, blue: LVL_3};
      4'd12:   p = '{red: LVL_3, green: LVL_1, blue: LVL_1};
      4'd13:   p = '{red: LVL_3, green: LVL_1, blue: LVL_3};
      4'd14:   p = '{red: LVL_3, green: LVL_3, blue: LVL_1};
      default: p = '{red: LVL_3, green: LVL_3, blue: LVL_3};
    endcase
    return p;
  endfunction

  // Absolute difference of two channel values
  function automatic chan_t abs_diff(chan_t a, chan_t b);
    chan_t d;
    if (a >= b) begin
      d = a - b;
    end else begin
      d = b - a;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/nearest_ega_color_quantizer_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_ega_color_quantizer_unit - RGB pixel to nearest EGA palette index
// Registers each pixel, finds the palette entry at the smallest Manhattan
// distance and holds the index in an output register.
//
//   channel  dir  signals                      payload
//   s_*      in   s_tvalid s_tready s_tdata    red, green, blue (8 b each)
//   m_*      out  m_tvalid m_tready m_tdata    color_index (4 b)
//
// One pixel per cycle sustained while m_tready is high; each pixel passes the
// input register, then the output register, before its result is presented.
// The distance lanes and the compare tree sit between the two registers.
// rst (synchronous) empties both registers; no result is lost or repeated.
// A stall on m_tready holds the output register and, once the input register
// is also full, drops s_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_ega_color_quantizer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [23:0] s_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [7:0]  m_tdata    // [3:0] color_index, [7:4] zero
);

  logic                in_valid;
  egaq_pkg::pixel_t    in_pixel;
  egaq_pkg::dist_vec_t pal_dist;
  egaq_pkg::idx_t      best_idx;
  egaq_pkg::idx_t      out_idx;
  logic                advance;

  // Output register may load when empty or being taken
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance || !in_valid;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_pixel <= egaq_pkg::pixel_t'(s_tdata);
    end
  end

  egaq_dist u_dist (
    .pixel    (in_pixel),
    .pal_dist (pal_dist)
  );

  egaq_argmin u_argmin (
    .pal_dist (pal_dist),
    .best_idx (best_idx)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_idx <= best_idx;
    end
  end

  assign m_tdata = {4'b0000, out_idx};

  // A pending pixel moves into a free output register
  a_move: assert property (@(posedge clk) disable iff (rst)
    (in_valid && advance) |=> m_tvalid)
    else $error("pending pixel did not reach the output register");

  // Output empties after a transfer with nothing behind it
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !in_valid) |=> !m_tvalid)
    else $error("result repeated after transfer");

  // Input side is never blocked while the output register is empty
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  // The index register only changes when a new result is loaded
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(out_idx))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== rtl/egaq_dist.sv =====
// ----------------------------------------------------------------------------
// egaq_dist - Manhattan distance to every palette entry
// Computes |dr| + |dg| + |db| from one pixel to all 16 entries in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module egaq_dist (
  input  egaq_pkg::pixel_t    pixel,
  output egaq_pkg::dist_vec_t pal_dist
);

  // One distance lane per palette entry
  for (genvar i = 0; i < egaq_pkg::PAL_SIZE; i++) begin : g_lane
    egaq_pkg::pixel_t entry;
    assign entry = egaq_pkg::pal_rgb(egaq_pkg::IDX_W'(i));
    assign pal_dist[i] =
        egaq_pkg::DIST_W'(egaq_pkg::abs_diff(pixel.red,   entry.red))
      + egaq_pkg::DIST_W'(egaq_pkg::abs_diff(pixel.green, entry.green))
      + egaq_pkg::DIST_W'(egaq_pkg::abs_diff(pixel.blue,  entry.blue));
  end

endmodule

`default_nettype wire

// ===== rtl/egaq_argmin.sv =====
// ----------------------------------------------------------------------------
// egaq_argmin - index of the smallest distance
// Four-level compare tree; the lower index is kept unless the higher one is
// strictly nearer, so ties resolve to the lowest index.
// ----------------------------------------------------------------------------
`default_nettype none

module egaq_argmin (
  input  egaq_pkg::dist_vec_t pal_dist,
  output egaq_pkg::idx_t      best_idx
);

  egaq_pkg::dist_t l1_d [8];
  egaq_pkg::idx_t  l1_i [8];
  egaq_pkg::dist_t l2_d [4];
  egaq_pkg::idx_t  l2_i [4];
  egaq_pkg::dist_t l3_d [2];
  egaq_pkg::idx_t  l3_i [2];

  // Reduce pairs level by level; right side wins only when strictly smaller
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      if (pal_dist[2*k+1] < pal_dist[2*k]) begin
        l1_d[k] = pal_dist[2*k+1];
        l1_i[k] = egaq_pkg::IDX_W'(2*k+1);
      end else begin
        l1_d[k] = pal_dist[2*k];
        l1_i[k] = egaq_pkg::IDX_W'(2*k);
      end
    end
    for (int k = 0; k < 4; k++) begin
      if (l1_d[2*k+1] < l1_d[2*k]) begin
        l2_d[k] = l1_d[2*k+1];
        l2_i[k] = l1_i[2*k+1];
      end else begin
        l2_d[k] = l1_d[2*k];
        l2_i[k] = l1_i[2*k];
      end
    end
    for (int k = 0; k < 2; k++) begin
      if (l2_d[2*k+1] < l2_d[2*k]) begin
        l3_d[k] = l2_d[2*k+1];
        l3_i[k] = l2_i[2*k+1];
      end else begin
        l3_d[k] = l2_d[2*k];
        l3_i[k] = l2_i[2*k];
      end
    end
    if (l3_d[1] < l3_d[0]) begin
      best_idx = l3_i[1];
    end else begin
      best_idx = l3_i[0];
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_nearest_ega_color_quantizer_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_ega_color_quantizer_unit - self-checking bench for the quantizer
// Streams RGB pixels into the unit and checks each returned palette index
// against a local nearest-color search over the 16 EGA entries. A directed
// part covers every palette entry, the channel extremes and equal-distance
// ties. Random pixels then run under varying idle and back-pressure patterns.
// ----------------------------------------------------------------------------

module tb_nearest_ega_color_quantizer_unit;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int unsigned DIST_CEILING   = 100000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;      // [7:0] red, [15:8] green, [23:16] blue
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;           // [3:0] color_index, [7:4] zero

  // Indexes still owed by the unit, oldest first
  egaq_pkg::idx_t color_index_q[$];
  int   error_count = 0;
  int   idle_cycles = 0;
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;

  nearest_ega_color_quantizer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // EGA entry color: each channel is a level code times 0x55
  function automatic egaq_pkg::pixel_t ega_color(int unsigned entry);
    logic [5:0]       code;
    egaq_pkg::pixel_t px;
    case (entry)
      0:       code = 6'b00_00_00;
      1:       code = 6'b00_00_10;
      2:       code = 6'b00_10_00;
      3:       code = 6'b00_10_10;
      4:       code = 6'b10_00_00;
      5:       code = 6'b10_00_10;
      6:       code = 6'b10_01_00;
      7:       code = 6'b10_10_10;
      8:       code = 6'b01_01_01;
      9:       code = 6'b01_01_11;
      10:      code = 6'b01_11_01;
      11:      code = 6'b01_11_11;
      12:      code = 6'b11_01_01;
      13:      code = 6'b11_01_11;
      14:      code = 6'b11_11_01;
      default: code = 6'b11_11_11;
    endcase
    px.red   = egaq_pkg::chan_t'(code[5:4] * 8'h55);
    px.green = egaq_pkg::chan_t'(code[3:2] * 8'h55);
    px.blue  = egaq_pkg::chan_t'(code[1:0] * 8'h55);
    return px;
  endfunction

  // Nearest entry by sum of absolute channel differences; strict compare
  // keeps the lowest index on a tie
  function automatic egaq_pkg::idx_t nearest_ega_index(egaq_pkg::pixel_t px);
    int unsigned      best_dist;
    int unsigned      entry_dist;
    egaq_pkg::idx_t   best_idx;
    egaq_pkg::pixel_t pal;
    best_dist = DIST_CEILING;
    best_idx  = '0;
    for (int unsigned i = 0; i < egaq_pkg::PAL_SIZE; i++) begin
      pal  = ega_color(i);
      entry_dist = ((px.red   > pal.red)   ? px.red   - pal.red   : pal.red   - px.red)
                 + ((px.green > pal.green) ? px.green - pal.green : pal.green - px.green)
                 + ((px.blue  > pal.blue)  ? px.blue  - pal.blue  : pal.blue  - px.blue);
      if (entry_dist < best_dist) begin
        best_dist = entry_dist;
        best_idx  = egaq_pkg::idx_t'(i);
      end
    end
    return best_idx;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Drive one pixel and hold it until the transfer completes
  task automatic send_pixel(input egaq_pkg::pixel_t px);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Check results first, then queue the index owed for an accepted pixel
  always @(posedge clk) begin : check_results
    egaq_pkg::idx_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (color_index_q.size() == 0) begin
          report_mismatch("result with nothing pending", m_tdata[3:0], 0);
        end else begin
          want = color_index_q.pop_front();
          if (m_tdata[3:0] != want) begin
            report_mismatch("color_index", m_tdata[3:0], want);
          end
          if (m_tdata[7:4] != 4'h0) begin
            report_mismatch("tdata padding", m_tdata[7:4], 0);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        color_index_q = {color_index_q,
                         nearest_ega_index(egaq_pkg::pixel_t'(s_tdata))};
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_nearest_ega_color_quantizer_unit: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Every palette color must map to its own entry
  task automatic test_palette_entries();
    for (int unsigned i = 0; i < egaq_pkg::PAL_SIZE; i++) begin
      send_pixel(ega_color(i));
    end
  endtask

  // Channel extremes, midpoints and equal-distance ties
  task automatic test_extremes_and_ties();
    egaq_pkg::pixel_t px;
    px = '{red: 8'hff, green: 8'h00, blue: 8'h00}; send_pixel(px);
    px = '{red: 8'h00, green: 8'hff, blue: 8'h00}; send_pixel(px);
    px = '{red: 8'h00, green: 8'h00, blue: 8'hff}; send_pixel(px);
    px = '{red: 8'hff, green: 8'h00, blue: 8'hff}; send_pixel(px);
    // halfway between black and dark blue: black wins the tie
    px = '{red: 8'h00, green: 8'h00, blue: 8'h55}; send_pixel(px);
    // equally near gray and light blue
    px = '{red: 8'h55, green: 8'h55, blue: 8'haa}; send_pixel(px);
    px = '{red: 8'h7f, green: 8'h7f, blue: 8'h7f}; send_pixel(px);
    px = '{red: 8'h80, green: 8'h80, blue: 8'h80}; send_pixel(px);
  endtask

  // Random pixels: uniform, near a palette color, or on tie-prone levels
  task automatic test_random_pixels(input int count, input int idle_pct,
                                    input int stall_pct);
    egaq_pkg::pixel_t px;
    egaq_pkg::pixel_t pal;
    egaq_pkg::chan_t  levels [10] = '{8'h00, 8'h2a, 8'h2b, 8'h55, 8'h7f,
                                      8'h80, 8'haa, 8'hd4, 8'hd5, 8'hff};
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(3))
        0: begin
          pal = ega_color($urandom_range(egaq_pkg::PAL_SIZE - 1));
          px.red   = egaq_pkg::chan_t'(int'(pal.red)   + $urandom_range(40) - 20);
          px.green = egaq_pkg::chan_t'(int'(pal.green) + $urandom_range(40) - 20);
          px.blue  = egaq_pkg::chan_t'(int'(pal.blue)  + $urandom_range(40) - 20);
        end
        1: begin
          px.red   = levels[$urandom_range(9)];
          px.green = levels[$urandom_range(9)];
          px.blue  = levels[$urandom_range(9)];
        end
        default: begin
          px = egaq_pkg::pixel_t'(24'($urandom()));
        end
      endcase
      send_pixel(px);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_palette_entries();
    test_extremes_and_ties();
    test_random_pixels(200, 0, 0);
    test_random_pixels(200, 50, 0);
    test_random_pixels(200, 0, 50);
    test_random_pixels(200, 23, 23);

    // Drop valid and let the pipeline drain
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (color_index_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_nearest_ega_color_quantizer_unit: done, clean");
    end else begin
      $display("tb_nearest_ega_color_quantizer_unit: done, errors");
    end
    $finish;
  end

endmodule
